// ===== rtl/sfd_pkg.sv =====
// Shared types and constants for the stuffed frame deframer.
// No dependencies; used by sfd_core, sfd_out_skid and stuffed_frame_deframer.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_CODE_ESC  = 8'h01;
  localparam logic [7:0] ESC_CODE_FLAG = 8'h02;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_BAD_ESC = 2'd2;

  typedef struct packed {
    logic [1:0] frame_status;
    logic       last;
    logic       has_byte;
    logic [7:0] out_byte;
  } sfd_result_t;

endpackage

// ===== rtl/sfd_core.sv =====
// Frame state and unstuffing logic: one raw byte in, at most one result out.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_valid,
  input  logic [7:0]         rx_byte,
  input  logic               byte_fire,
  output logic               res_valid,
  output sfd_pkg::sfd_result_t res
);

  logic       esc_pend_r, esc_pend_nxt;
  logic       seen_first_r, seen_first_nxt;
  logic       esc_err_r, esc_err_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic       have_d;
  logic [7:0] d;
  logic       produce;

  always_comb begin
    esc_pend_nxt   = esc_pend_r;
    seen_first_nxt = seen_first_r;
    esc_err_nxt    = esc_err_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    sum_nxt        = sum_r;
    have_d         = 1'b0;
    d              = rx_byte;
    produce        = 1'b0;
    res            = '0;

    if (rx_byte == sfd_pkg::FLAG_BYTE) begin
      // closing delimiter; an empty frame reports nothing
      produce = seen_first_r || esc_pend_r || esc_err_r;
      res.last = 1'b1;
      if (esc_err_r || esc_pend_r)
        res.frame_status = sfd_pkg::ST_BAD_ESC;
      else if (sum_r == 8'd0)
        res.frame_status = sfd_pkg::ST_GOOD;
      else
        res.frame_status = sfd_pkg::ST_BAD_SUM;
      if (held_valid_r) begin
        res.out_byte = held_byte_r;
        res.has_byte = 1'b1;
      end
      esc_pend_nxt   = 1'b0;
      seen_first_nxt = 1'b0;
      esc_err_nxt    = 1'b0;
      held_valid_nxt = 1'b0;
      sum_nxt        = 8'd0;
    end else if (esc_pend_r) begin
      esc_pend_nxt = 1'b0;
      if (rx_byte == sfd_pkg::ESC_CODE_ESC) begin
        d      = sfd_pkg::ESC_BYTE;
        have_d = 1'b1;
      end else if (rx_byte == sfd_pkg::ESC_CODE_FLAG) begin
        d      = sfd_pkg::FLAG_BYTE;
        have_d = 1'b1;
      end else begin
        esc_err_nxt = 1'b1;
      end
    end else if (rx_byte == sfd_pkg::ESC_BYTE) begin
      esc_pend_nxt = 1'b1;
    end else begin
      have_d = 1'b1;
    end

    if (have_d) begin
      sum_nxt = sum_r + d;
      if (!seen_first_r) begin
        // checksum byte: summed, not forwarded
        seen_first_nxt = 1'b1;
      end else begin
        produce        = held_valid_r;
        res.out_byte   = held_byte_r;
        res.has_byte   = 1'b1;
        held_byte_nxt  = d;
        held_valid_nxt = 1'b1;
      end
    end

    res_valid = byte_valid && produce;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r   <= 1'b0;
      seen_first_r <= 1'b0;
      esc_err_r    <= 1'b0;
      held_valid_r <= 1'b0;
      sum_r        <= 8'd0;
    end else if (byte_fire) begin
      esc_pend_r   <= esc_pend_nxt;
      seen_first_r <= seen_first_nxt;
      esc_err_r    <= esc_err_nxt;
      held_valid_r <= held_valid_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire)
      held_byte_r <= held_byte_nxt;
  end

endmodule

// ===== rtl/sfd_out_skid.sv =====
// Output register with skid entry; ready toward the core is registered.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfd_pkg::sfd_result_t in_res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfd_pkg::sfd_result_t out_res
);

  logic                 main_valid_r;
  logic                 skid_valid_r;
  sfd_pkg::sfd_result_t main_r;
  sfd_pkg::sfd_result_t skid_r;
  logic                 acc;
  logic                 load_main;

  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && !skid_valid_r;
  assign load_main = !main_valid_r || out_ready;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_main) begin
      main_valid_r <= skid_valid_r || acc;
      skid_valid_r <= 1'b0;
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      if (skid_valid_r)
        main_r <= skid_r;
      else if (acc)
        main_r <= in_res;
    end else if (acc) begin
      skid_r <= in_res;
    end
  end

endmodule

// ===== rtl/stuffed_frame_deframer.sv =====
// Path: an input transaction reaches out_tvalid through the input register,
// then the result register; payload bytes leave one byte late.
// Throughput: 1 byte per cycle unless a full output buffer holds a result; the frame state update is a compare and an
// 8-bit add between the input register and the output register.
// Reset (rst_n low, synchronous): frame state cleared, no result pending.
`timescale 1ns / 1ps

module stuffed_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [2:0] out_tuser   // [0] has_byte, [2:1] frame_status
);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_fire;
  logic                 res_valid;
  logic                 skid_ready;
  sfd_pkg::sfd_result_t res;
  sfd_pkg::sfd_result_t out_res;

  // bytes with no result may retire even when the output side is full
  assign s1_fire   = s1_valid_r && (skid_ready || !res_valid);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_valid_r <= 1'b0;
    else if (in_tready)
      s1_valid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid)
      s1_byte_r <= in_tdata;
  end

  sfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_valid_r),
    .rx_byte    (s1_byte_r),
    .byte_fire  (s1_fire),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (res_valid && s1_fire),
    .in_ready  (skid_ready),
    .in_res    (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.out_byte;
  assign out_tlast = out_res.last;
  assign out_tuser = {out_res.frame_status, out_res.has_byte};

  a_status_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[2:1] == sfd_pkg::ST_GOOD)
    else $error("frame_status set on a non-closing result");

  a_empty_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("result without byte that does not close a frame");

  a_no_result_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_valid |-> skid_ready)
    else $error("result issued while output buffer full");

  a_status_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] != 2'd3)
    else $error("undefined frame status");

endmodule
